[rtl/mvps_pkg.sv]
// ----------------------------------------------------------------------------
// mvps_pkg: shared types and constants of the multi-voice pluck synth
// word layouts of the three channels, the control bundle broadcast to the
// voice cells, the sequencer states and the normalisation gain table
// ----------------------------------------------------------------------------
package mvps_pkg;

	// default sizes of the voice row
	localparam int VOICES_DEF     = 8;
	localparam int PHASE_BITS_DEF = 24;
	localparam int SINE_BITS_DEF  = 10;

	// fixed widths
	localparam int IDX_W     = 18;
	localparam int COUNT_W   = 5;
	localparam int GAIN_W    = 17;
	localparam int TERM_W    = 35;
	localparam int MIX_SHIFT = 47;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// sine polynomial coefficients, q15
	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [14:0] SIN_B = 15'd21024;
	localparam logic [11:0] SIN_C = 12'd2320;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  voice_slot;
		logic [23:0] phase_step;
		logic [16:0] start_delay;
		logic [16:0] voice_length;
		logic [15:0] decay_factor;
		logic [15:0] amplitude;
	} in_word_t;

	typedef struct packed {
		logic [7:0] sample;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [3:0] voice_count;
	} cfg_word_t;

	// control broadcast from the sequencer to every voice cell
	typedef struct packed {
		logic               load;
		logic               go;
		logic [IDX_W-1:0]   index;
		logic [COUNT_W-1:0] in_use;
		in_word_t           wr;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	// round(65536 / sqrt(n)) for n voices in use
	function automatic logic [GAIN_W-1:0] gain_q16(input logic [COUNT_W-1:0] n);
		logic [GAIN_W-1:0] g;
		unique case (n)
			5'd1:    g = 17'd65536;
			5'd2:    g = 17'd46341;
			5'd3:    g = 17'd37837;
			5'd4:    g = 17'd32768;
			5'd5:    g = 17'd29309;
			5'd6:    g = 17'd26755;
			5'd7:    g = 17'd24770;
			5'd8:    g = 17'd23170;
			5'd9:    g = 17'd21845;
			5'd10:   g = 17'd20725;
			5'd11:   g = 17'd19760;
			5'd12:   g = 17'd18919;
			5'd13:   g = 17'd18177;
			5'd14:   g = 17'd17515;
			5'd15:   g = 17'd16921;
			5'd16:   g = 17'd16384;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

[rtl/mvps_chan_if.sv]
// ----------------------------------------------------------------------------
// mvps_chan_if: valid/ready channel
// carries one word of the given type per handshake
// ----------------------------------------------------------------------------
interface mvps_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/multi_voice_pluck_synth.sv]
// ----------------------------------------------------------------------------
// multi_voice_pluck_synth: additive sine synth with decaying envelopes
// a tick passes a six-stage term pipeline in every cell, one sum register
// per cell as the sum moves along the row, two scaling stages and the output
// word register; it gives a word on the result channel only before the end of
// the sequence, a load gives none, and no new item is taken while a tick is in flight
// after reset all phases, envelopes and the sample index are zero and the
// voice count is one; the voice tables hold nothing until loaded
// ----------------------------------------------------------------------------
module multi_voice_pluck_synth import mvps_pkg::*; #(
	parameter int VOICES          = VOICES_DEF,
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mvps_chan_if.sink    cfg,
	mvps_chan_if.sink    item,
	mvps_chan_if.source  result
);

	localparam int SUM_W = TERM_W + $clog2(VOICES);
	localparam int CNT_W = $clog2(VOICES + 9);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(VOICES + 8);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [IDX_W-1:0]   index_q, index_d;
	logic [3:0]         count_q;
	logic [COUNT_W-1:0] in_use;
	logic               item_acc;
	logic               load_out;
	logic               out_valid_q;
	out_word_t          out_word_q;
	cell_ctrl_t         ctrl;

	logic signed [SUM_W-1:0] sum_chain [VOICES+1];
	logic        [IDX_W-1:0] end_chain [VOICES+1];

	logic [7:0] mix_sample;
	logic       mix_emit;
	logic       mix_last;

	assign item_acc     = item.valid && item.ready;
	assign item.ready   = state_q == ST_IDLE;
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

	// voices in use, capped at the size of the row
	assign in_use = (COUNT_W'(count_q) > COUNT_W'(VOICES)) ? COUNT_W'(VOICES)
		: COUNT_W'(count_q);

	// broadcast to the cells
	always_comb begin
		ctrl.load   = item_acc && (item.data.req_type == REQ_LOAD);
		ctrl.go     = (state_q == ST_RUN) && (cnt_q == '0);
		ctrl.index  = index_q;
		ctrl.in_use = in_use;
		ctrl.wr     = item.data;
	end

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		index_d  = index_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					if (item.data.req_type == REQ_TICK) begin
						state_d = ST_RUN;
						cnt_d   = '0;
					end else begin
						index_d = '0;
					end
				end
			end
			ST_RUN: begin
				if (cnt_q == LAST_CNT) begin
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || result.ready) begin
					load_out = mix_emit;
					if (mix_emit) begin
						index_d = index_q + 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer registers and voice count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			index_q <= '0;
			count_q <= 4'd1;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			index_q <= index_d;
			if (cfg.valid && cfg.ready) begin
				count_q <= cfg.data.voice_count;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_word_q.sample <= mix_sample;
			out_word_q.last   <= mix_last;
		end
	end

	// row of voice cells
	assign sum_chain[0] = '0;
	assign end_chain[0] = '0;

	for (genvar g = 0; g < VOICES; g++) begin : g_cell
		mvps_voice_cell #(
			.VOICES          (VOICES),
			.PHASE_BITS      (PHASE_BITS),
			.SINE_TABLE_BITS (SINE_TABLE_BITS),
			.K               (g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.sum_in  (sum_chain[g]),
			.end_in  (end_chain[g]),
			.sum_out (sum_chain[g+1]),
			.end_out (end_chain[g+1])
		);
	end

	// gain, clamp and sample mapping
	mvps_mix #(
		.VOICES (VOICES)
	) u_mix (
		.clk       (clk),
		.sum_in    (sum_chain[VOICES]),
		.end_total (end_chain[VOICES]),
		.index     (index_q),
		.in_use    (in_use),
		.sample    (mix_sample),
		.emit      (mix_emit),
		.last      (mix_last)
	);

endmodule

[rtl/mvps_voice_cell.sv]
// ----------------------------------------------------------------------------
// mvps_voice_cell: one voice of the synth
// holds the voice parameters, phase and envelope, works out its sine term
// through a short multiply pipeline and adds it to the running sum that
// moves along the row of cells
// ----------------------------------------------------------------------------
module mvps_voice_cell import mvps_pkg::*; #(
	parameter int VOICES          = VOICES_DEF,
	parameter int PHASE_BITS      = PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_BITS_DEF,
	parameter int K               = 0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  cell_ctrl_t                                    ctrl,
	input  logic signed [TERM_W+$clog2(VOICES)-1:0]       sum_in,
	input  logic        [IDX_W-1:0]                       end_in,
	output logic signed [TERM_W+$clog2(VOICES)-1:0]       sum_out,
	output logic        [IDX_W-1:0]                       end_out
);

	localparam int SUM_W = TERM_W + $clog2(VOICES);
	localparam logic [COUNT_W-1:0] SLOT_ID = COUNT_W'(K);

	// voice parameters, written by a load
	logic [PHASE_BITS-1:0] step_q;
	logic [16:0]           delay_q;
	logic [16:0]           length_q;
	logic [15:0]           decay_q;
	logic [15:0]           amp_q;

	// running voice state
	logic [PHASE_BITS-1:0] phase_q;
	logic [15:0]           env_q;

	logic                  wr_hit;
	logic                  in_use_k;
	logic [IDX_W-1:0]      dly;
	logic [IDX_W-1:0]      rel;
	logic                  act;
	logic                  first;
	logic [PHASE_BITS-1:0] ph_used;
	logic [15:0]           env_used;
	logic [31:0]           env_prod;
	logic [IDX_W-1:0]      my_end;

	// pipeline
	logic                       act_s1, act_s2, act_s3, act_s4, act_s5;
	logic [SINE_TABLE_BITS-1:0] idx_s1;
	logic [15:0]                env_s1, env_s2, env_s3, env_s4, env_s5;
	logic [15:0]                ax_s2, ax_s3, ax_s4;
	logic                       neg_s2, neg_s3, neg_s4;
	logic [15:0]                x2_s2, x2_s3;
	logic [14:0]                inner_s3;
	logic [15:0]                mid_s4;
	logic signed [17:0]         y_s5;
	logic signed [TERM_W-1:0]   term_s6;

	logic [17:0] p18;
	logic [15:0] ax;
	logic        neg;
	logic [31:0] prod2;
	logic [27:0] prod3;
	logic [30:0] prod4;
	logic [31:0] prod5;
	logic [16:0] y;

	logic signed [SUM_W-1:0] sum_q;
	logic        [IDX_W-1:0] end_q;

	// which voice this is, and whether it sounds at the current index
	assign wr_hit   = ctrl.load && ({2'b00, ctrl.wr.voice_slot} == SLOT_ID);
	assign in_use_k = ctrl.in_use > SLOT_ID;
	assign dly      = {1'b0, delay_q};
	assign rel      = ctrl.index - dly;
	assign act      = in_use_k && (ctrl.index >= dly) && (rel < {1'b0, length_q});
	assign first    = ctrl.index == dly;
	assign ph_used  = first ? '0 : phase_q;
	assign env_used = first ? amp_q : env_q;
	assign env_prod = 32'(env_used) * 32'(decay_q);
	assign my_end   = {1'b0, delay_q} + {1'b0, length_q};

	// parameter table of this slot
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			step_q   <= PHASE_BITS'(ctrl.wr.phase_step);
			delay_q  <= ctrl.wr.start_delay;
			length_q <= ctrl.wr.voice_length;
			decay_q  <= ctrl.wr.decay_factor;
			amp_q    <= ctrl.wr.amplitude;
		end
	end

	// phase and envelope clear on a load and advance once per sample while sounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			env_q   <= '0;
		end else if (ctrl.load) begin
			phase_q <= '0;
			env_q   <= '0;
		end else if (ctrl.go && act) begin
			phase_q <= ph_used + step_q;
			env_q   <= env_prod[31:16];
		end
	end

	// stage 1: capture the phase and envelope used for this sample
	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			act_s1 <= act;
			idx_s1 <= ph_used[PHASE_BITS-1 -: SINE_TABLE_BITS];
			env_s1 <= env_used;
		end
	end

	// fold the phase onto a quarter wave
	always_comb begin
		p18 = {1'b0, idx_s1, {(17-SINE_TABLE_BITS){1'b0}}};
		priority if (p18 <= 18'd32768) begin
			ax  = 16'(p18);
			neg = 1'b0;
		end else if (p18 <= 18'd98304) begin
			if (p18 > 18'd65536) begin
				ax  = 16'(p18 - 18'd65536);
				neg = 1'b1;
			end else begin
				ax  = 16'(18'd65536 - p18);
				neg = 1'b0;
			end
		end else begin
			ax  = 16'(18'd131072 - p18);
			neg = 1'b1;
		end
	end

	assign prod2 = 32'(ax) * 32'(ax);
	assign prod3 = 28'(x2_s2) * 28'(SIN_C);
	assign prod4 = 31'(x2_s3) * 31'(inner_s3);
	assign prod5 = 32'(ax_s4) * 32'(mid_s4);
	assign y     = prod5[31:15];

	// stages 2 to 6: odd polynomial, then scale by the envelope
	always_ff @(posedge clk) begin
		act_s2   <= act_s1;
		env_s2   <= env_s1;
		ax_s2    <= ax;
		neg_s2   <= neg;
		x2_s2    <= prod2[30:15];

		act_s3   <= act_s2;
		env_s3   <= env_s2;
		ax_s3    <= ax_s2;
		neg_s3   <= neg_s2;
		x2_s3    <= x2_s2;
		inner_s3 <= SIN_B - {2'b00, prod3[27:15]};

		act_s4   <= act_s3;
		env_s4   <= env_s3;
		ax_s4    <= ax_s3;
		neg_s4   <= neg_s3;
		mid_s4   <= SIN_A - prod4[30:15];

		act_s5   <= act_s4;
		env_s5   <= env_s4;
		y_s5     <= neg_s4 ? -$signed({1'b0, y}) : $signed({1'b0, y});

		term_s6  <= act_s5 ? TERM_W'(y_s5 * $signed({1'b0, env_s5})) : '0;
	end

	// running sum and sequence end handed to the next cell
	always_ff @(posedge clk) begin
		sum_q <= sum_in + SUM_W'(term_s6);
		end_q <= (in_use_k && (my_end > end_in)) ? my_end : end_in;
	end

	assign sum_out = sum_q;
	assign end_out = end_q;

endmodule

[rtl/mvps_mix.sv]
// ----------------------------------------------------------------------------
// mvps_mix: output scaling
// applies the normalisation gain, clamps to full scale and maps the mix
// onto an unsigned 8-bit sample; also flags whether and where the
// sequence ends
// ----------------------------------------------------------------------------
module mvps_mix import mvps_pkg::*; #(
	parameter int VOICES = VOICES_DEF
) (
	input  logic                                    clk,
	input  logic signed [TERM_W+$clog2(VOICES)-1:0] sum_in,
	input  logic        [IDX_W-1:0]                 end_total,
	input  logic        [IDX_W-1:0]                 index,
	input  logic        [COUNT_W-1:0]               in_use,
	output logic        [7:0]                       sample,
	output logic                                    emit,
	output logic                                    last
);

	localparam int SUM_W   = TERM_W + $clog2(VOICES);
	localparam int MIX_W   = SUM_W + GAIN_W + 1;
	localparam int CLAMP_W = MIX_SHIFT + 2;
	localparam int SCALE_W = MIX_SHIFT + 9;
	localparam logic signed [MIX_W-1:0] MIX_HI =
		{{(MIX_W-MIX_SHIFT-1){1'b0}}, 1'b1, {MIX_SHIFT{1'b0}}};
	localparam logic signed [MIX_W-1:0] MIX_LO = -MIX_HI;

	logic signed [GAIN_W:0]    gain_s;
	logic signed [MIX_W-1:0]   mix_s1;
	logic                      emit_s1, last_s1;
	logic signed [CLAMP_W-1:0] clamp;
	logic signed [SCALE_W-1:0] scaled;
	logic        [7:0]         sample_s2;
	logic                      emit_s2, last_s2;

	assign gain_s = $signed({1'b0, gain_q16(in_use)});

	// stage 1: gain and end of sequence
	always_ff @(posedge clk) begin
		mix_s1  <= MIX_W'(sum_in) * MIX_W'(gain_s);
		emit_s1 <= index < end_total;
		last_s1 <= (index + 18'd1) == end_total;
	end

	// clamp to plus or minus one, then times 127 plus 128
	always_comb begin
		priority if (mix_s1 > MIX_HI) begin
			clamp = CLAMP_W'(MIX_HI);
		end else if (mix_s1 < MIX_LO) begin
			clamp = CLAMP_W'(MIX_LO);
		end else begin
			clamp = CLAMP_W'(mix_s1);
		end
		scaled = (SCALE_W'(clamp) <<< 7) - SCALE_W'(clamp);
	end

	// stage 2: final sample
	always_ff @(posedge clk) begin
		sample_s2 <= scaled[MIX_SHIFT+7:MIX_SHIFT] + 8'd128;
		emit_s2   <= emit_s1;
		last_s2   <= last_s1;
	end

	assign sample = sample_s2;
	assign emit   = emit_s2;
	assign last   = last_s2;

endmodule

[rtl/mvps_checker.sv]
// ----------------------------------------------------------------------------
// mvps_checker: port-level checks of the pluck synth
// watches the item and result channels and is bound to the top level
// ----------------------------------------------------------------------------
module mvps_checker import mvps_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_req_type,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_sample,
	input logic       out_last
);

	// a tick holds the block busy in the following cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_req_type == REQ_TICK)) |=> !in_ready)
		else $error("input taken right after a tick");

	// the clamp never lets a sample fall below one
	a_sample_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_sample != 8'd0))
		else $error("sample below clamped range");

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(out_sample) && $stable(out_last)))
		else $error("result word changed while stalled");

	// a new word only appears at the end of a tick, while input is held off
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word appeared while idle");

endmodule

bind multi_voice_pluck_synth mvps_checker u_mvps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.in_req_type (item.data.req_type),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_sample  (result.data.sample),
	.out_last    (result.data.last)
);
